[hdl/pdtw_pkg.sv]
// Package for the prescaled dual timer and watchdog: command and register codes,
// control-bit positions and the transaction payload types.
// No dependencies; compile first.
package pdtw_pkg;

    localparam int DATA_W = 24;
    localparam int IDX_W  = 4;
    localparam int CMD_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CNT1   = 4'd0,
        REG_RLD1   = 4'd1,
        REG_CTL1   = 4'd2,
        REG_WDOG   = 4'd3,
        REG_CNT2   = 4'd4,
        REG_RLD2   = 4'd5,
        REG_CTL2   = 4'd6,
        REG_PRECNT = 4'd8,
        REG_PRERLD = 4'd9
    } reg_idx_t;

    // control word layout
    localparam int CTL_EN_BIT = 0;
    localparam int CTL_AR_BIT = 1;
    localparam int CTL_LD_BIT = 2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_timer_one;
        logic              irq_timer_two;
        logic              irq_watchdog;
    } rsp_t;

endpackage

[hdl/pdtw_stream_if.sv]
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is a parameter; used with pdtw_pkg::req_t and pdtw_pkg::rsp_t.
interface pdtw_stream_if #(
    parameter type payload_t = logic [0:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/prescaled_dual_timer_watchdog.sv]
// Top level of the prescaled dual timer with watchdog.
// Depends on pdtw_pkg and pdtw_stream_if.
//
//   channel    modport  payload         role
//   ---------  -------  --------------  -------------------------------------
//   request    sink     pdtw_pkg::req_t tick, register write or register read
//   response   source   pdtw_pkg::rsp_t read data and per-tick interrupts
//
// Every request transaction produces exactly one response transaction, held in
// a single output register. The state update happens in the accept cycle, so a
// request can be taken every cycle; its response is valid the next cycle.
// request.ready is low only while the output register is full and response is
// stalled. rst_n (asynchronous, active low) clears all counters, reloads,
// control bits and the output valid flag.
module prescaled_dual_timer_watchdog #(
    parameter int COUNT_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    pdtw_stream_if.sink     request,
    pdtw_stream_if.source   response
);

    // common width that holds both a counter and a data field
    localparam int WIDE_W = (COUNT_BITS > pdtw_pkg::DATA_W) ? COUNT_BITS : pdtw_pkg::DATA_W;

    // timer state
    logic [COUNT_BITS-1:0] pre_cnt_reg, pre_cnt_next;
    logic [COUNT_BITS-1:0] pre_rld_reg, pre_rld_next;
    logic [COUNT_BITS-1:0] tmr_cnt_reg [2];
    logic [COUNT_BITS-1:0] tmr_cnt_next [2];
    logic [COUNT_BITS-1:0] tmr_rld_reg [2];
    logic [COUNT_BITS-1:0] tmr_rld_next [2];
    logic [1:0]            tmr_en_reg, tmr_en_next;
    logic [1:0]            tmr_ar_reg, tmr_ar_next;
    logic [COUNT_BITS-1:0] wdg_cnt_reg, wdg_cnt_next;
    logic                  wdg_armed_reg, wdg_armed_next;

    // output register
    pdtw_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg, rsp_valid_next;

    pdtw_pkg::req_t        req;
    logic                  accept;
    logic [COUNT_BITS-1:0] wr_val;
    logic [WIDE_W-1:0]     wr_wide;
    logic [WIDE_W-1:0]     rd_wide;

    // Take a new transaction whenever the output register is free or draining.
    assign request.ready    = !rsp_valid_reg || response.ready;
    assign accept           = request.valid && request.ready;
    assign req              = request.payload;
    assign response.valid   = rsp_valid_reg;
    assign response.payload = rsp_reg;

    // Mask the written value to the counter width.
    assign wr_wide = WIDE_W'(req.write_data);
    assign wr_val  = wr_wide[COUNT_BITS-1:0];

    always_comb
    begin
        logic pre_zero;
        logic wdg_zero;
        logic [1:0] tmr_irq;
        logic wdg_irq;

        pre_cnt_next   = pre_cnt_reg;
        pre_rld_next   = pre_rld_reg;
        tmr_cnt_next   = tmr_cnt_reg;
        tmr_rld_next   = tmr_rld_reg;
        tmr_en_next    = tmr_en_reg;
        tmr_ar_next    = tmr_ar_reg;
        wdg_cnt_next   = wdg_cnt_reg;
        wdg_armed_next = wdg_armed_reg;
        rd_wide        = '0;
        tmr_irq        = '0;
        wdg_irq        = 1'b0;
        pre_zero       = (pre_cnt_reg == '0);
        wdg_zero       = (wdg_cnt_reg == '0);

        if (accept)
        begin
            unique case (req.cmd)
                pdtw_pkg::CMD_TICK:
                begin
                    // Count the prescaler down; on underflow reload it and
                    // tick both timers and the watchdog.
                    if (pre_zero)
                    begin
                        pre_cnt_next = pre_rld_reg;
                        for (int t = 0; t < 2; t++)
                        begin
                            if (tmr_en_reg[t])
                            begin
                                tmr_cnt_next[t] = tmr_cnt_reg[t] - COUNT_BITS'(1);
                                if (tmr_cnt_reg[t] == '0)
                                begin
                                    tmr_irq[t] = 1'b1;
                                    if (tmr_ar_reg[t])
                                        tmr_cnt_next[t] = tmr_rld_reg[t];
                                    else
                                        tmr_en_next[t] = 1'b0; // stop at all ones
                                end
                            end
                        end
                        if (wdg_armed_reg)
                        begin
                            // wraps to all ones on underflow and holds there
                            wdg_cnt_next = wdg_cnt_reg - COUNT_BITS'(1);
                            if (wdg_zero)
                            begin
                                wdg_irq        = 1'b1;
                                wdg_armed_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        pre_cnt_next = pre_cnt_reg - COUNT_BITS'(1);
                    end
                end
                pdtw_pkg::CMD_WRITE:
                begin
                    unique case (req.reg_index)
                        pdtw_pkg::REG_CNT1:   tmr_cnt_next[0] = wr_val;
                        pdtw_pkg::REG_RLD1:   tmr_rld_next[0] = wr_val;
                        pdtw_pkg::REG_CTL1:
                        begin
                            tmr_en_next[0] = wr_val[pdtw_pkg::CTL_EN_BIT];
                            tmr_ar_next[0] = wr_val[pdtw_pkg::CTL_AR_BIT];
                            if (wr_val[pdtw_pkg::CTL_LD_BIT])
                                tmr_cnt_next[0] = tmr_rld_reg[0];
                        end
                        pdtw_pkg::REG_WDOG:
                        begin
                            wdg_cnt_next   = wr_val;
                            wdg_armed_next = 1'b1;
                        end
                        pdtw_pkg::REG_CNT2:   tmr_cnt_next[1] = wr_val;
                        pdtw_pkg::REG_RLD2:   tmr_rld_next[1] = wr_val;
                        pdtw_pkg::REG_CTL2:
                        begin
                            tmr_en_next[1] = wr_val[pdtw_pkg::CTL_EN_BIT];
                            tmr_ar_next[1] = wr_val[pdtw_pkg::CTL_AR_BIT];
                            if (wr_val[pdtw_pkg::CTL_LD_BIT])
                                tmr_cnt_next[1] = tmr_rld_reg[1];
                        end
                        pdtw_pkg::REG_PRECNT: pre_cnt_next = wr_val;
                        pdtw_pkg::REG_PRERLD: pre_rld_next = wr_val;
                        default: ;
                    endcase
                end
                pdtw_pkg::CMD_READ:
                begin
                    unique case (req.reg_index)
                        pdtw_pkg::REG_CNT1:   rd_wide = WIDE_W'(tmr_cnt_reg[0]);
                        pdtw_pkg::REG_RLD1:   rd_wide = WIDE_W'(tmr_rld_reg[0]);
                        pdtw_pkg::REG_CTL1:   rd_wide = WIDE_W'({tmr_ar_reg[0], tmr_en_reg[0]});
                        pdtw_pkg::REG_WDOG:   rd_wide = WIDE_W'(wdg_cnt_reg);
                        pdtw_pkg::REG_CNT2:   rd_wide = WIDE_W'(tmr_cnt_reg[1]);
                        pdtw_pkg::REG_RLD2:   rd_wide = WIDE_W'(tmr_rld_reg[1]);
                        pdtw_pkg::REG_CTL2:   rd_wide = WIDE_W'({tmr_ar_reg[1], tmr_en_reg[1]});
                        pdtw_pkg::REG_PRECNT: rd_wide = WIDE_W'(pre_cnt_reg);
                        pdtw_pkg::REG_PRERLD: rd_wide = WIDE_W'(pre_rld_reg);
                        default:              rd_wide = '0;
                    endcase
                end
                default: ; // unused command: no state change
            endcase
        end

        // Load the output register on accept; drop valid once taken.
        rsp_next.read_data     = rd_wide[pdtw_pkg::DATA_W-1:0];
        rsp_next.irq_timer_one = tmr_irq[0];
        rsp_next.irq_timer_two = tmr_irq[1];
        rsp_next.irq_watchdog  = wdg_irq;

        if (accept)
            rsp_valid_next = 1'b1;
        else if (response.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_cnt_reg    <= '0;
            pre_rld_reg    <= '0;
            tmr_cnt_reg[0] <= '0;
            tmr_cnt_reg[1] <= '0;
            tmr_rld_reg[0] <= '0;
            tmr_rld_reg[1] <= '0;
            tmr_en_reg     <= '0;
            tmr_ar_reg     <= '0;
            wdg_cnt_reg    <= '0;
            wdg_armed_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            pre_cnt_reg    <= pre_cnt_next;
            pre_rld_reg    <= pre_rld_next;
            tmr_cnt_reg    <= tmr_cnt_next;
            tmr_rld_reg    <= tmr_rld_next;
            tmr_en_reg     <= tmr_en_next;
            tmr_ar_reg     <= tmr_ar_next;
            wdg_cnt_reg    <= wdg_cnt_next;
            wdg_armed_reg  <= wdg_armed_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Hold the response payload until a new transaction replaces it.
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

endmodule

[hdl/pdtw_checker.sv]
// Port-level checks for prescaled_dual_timer_watchdog, bound to the top level.
// Depends on pdtw_pkg.
module pdtw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic [pdtw_pkg::CMD_W-1:0]    req_cmd,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [pdtw_pkg::DATA_W-1:0]   rsp_read_data,
    input logic                          rsp_irq_one,
    input logic                          rsp_irq_two,
    input logic                          rsp_irq_wdg
);

    logic req_fire;
    logic rsp_fire;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // a stalled response stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // every accepted request yields a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid)
        else $error("no response after accepted request");

    // no response appears without a request behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_fire || !rsp_valid) && !req_fire |=> !rsp_valid)
        else $error("response invented");

    // a write answers with all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_cmd == pdtw_pkg::CMD_WRITE |=>
            rsp_read_data == '0 && !rsp_irq_one && !rsp_irq_two && !rsp_irq_wdg)
        else $error("write response not zero");

    // an empty output register never blocks the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty output");

endmodule

bind prescaled_dual_timer_watchdog pdtw_checker u_pdtw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (request.valid),
    .req_ready     (request.ready),
    .req_cmd       (request.payload.cmd),
    .rsp_valid     (response.valid),
    .rsp_ready     (response.ready),
    .rsp_read_data (response.payload.read_data),
    .rsp_irq_one   (response.payload.irq_timer_one),
    .rsp_irq_two   (response.payload.irq_timer_two),
    .rsp_irq_wdg   (response.payload.irq_watchdog)
);

[tb/sv/prescaled_dual_timer_watchdog_tb.sv]
// Self-checking testbench for prescaled_dual_timer_watchdog: directed and random
// ticks, register writes and reads, checked against an in-bench predictor.
// Depends on pdtw_pkg, pdtw_stream_if and the prescaled_dual_timer_watchdog RTL.
module prescaled_dual_timer_watchdog_tb;

    import pdtw_pkg::*;

    // cmd 3 and the register holes are not in the package enums
    localparam logic [CMD_W-1:0] CMD_IDLE_CODE = 2'd3;
    localparam logic [IDX_W-1:0] REG_HOLE      = 4'd7;
    localparam logic [IDX_W-1:0] REG_TOP       = 4'd15;

    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 5;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_TRICKLE
    } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    pdtw_stream_if #(.payload_t(req_t)) req_if ();
    pdtw_stream_if #(.payload_t(rsp_t)) rsp_if ();

    prescaled_dual_timer_watchdog #(
        .COUNT_BITS(DATA_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .response(rsp_if)
    );

    // Free-running clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted block state: prescaler, two timers, watchdog.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] scale_cnt;
    logic [DATA_W-1:0] scale_rld;
    logic [DATA_W-1:0] tmr_cnt [0:1];
    logic [DATA_W-1:0] tmr_rld [0:1];
    logic              tmr_on [0:1];
    logic              tmr_repeat [0:1];
    logic [DATA_W-1:0] wd_cnt;
    logic              wd_live;

    // Responses still owed by the block, oldest first.
    rsp_t pending_rsp [$];

    int   error_count  = 0;
    int   useful_items = 0;

    // Sender burst shaping; gaps_on = 0 gives a stretch with no idling.
    int   burst_left   = 0;
    bit   gaps_on      = 1'b1;

    // Toggle to ask the response side for a long hold-off.
    logic hold_token   = 1'b0;

    // Advance one timer on a prescaler underflow; return its interrupt.
    function automatic logic tick_timer(input int t);
        logic was_zero;
        if (!tmr_on[t])
            return 1'b0;
        was_zero   = (tmr_cnt[t] == '0);
        tmr_cnt[t] = tmr_cnt[t] - 1'b1;
        if (!was_zero)
            return 1'b0;
        // underflow: reload and keep going, or stop and drop enable
        if (tmr_repeat[t])
            tmr_cnt[t] = tmr_rld[t];
        else
            tmr_on[t] = 1'b0;
        return 1'b1;
    endfunction

    function automatic void set_control(input int t, input logic [DATA_W-1:0] d);
        tmr_on[t]     = d[CTL_EN_BIT];
        tmr_repeat[t] = d[CTL_AR_BIT];
        if (d[CTL_LD_BIT])
            tmr_cnt[t] = tmr_rld[t];
    endfunction

    // Control readback: the load bit always reads as zero.
    function automatic logic [DATA_W-1:0] control_word(input int t);
        logic [DATA_W-1:0] w;
        w             = '0;
        w[CTL_EN_BIT] = tmr_on[t];
        w[CTL_AR_BIT] = tmr_repeat[t];
        return w;
    endfunction

    // Apply one accepted transaction to the predicted state and return the
    // response the block must give for it.
    function automatic rsp_t next_response(input req_t r);
        rsp_t              res;
        logic [DATA_W-1:0] d;
        res = '0;
        d   = r.write_data;
        case (r.cmd)
            CMD_TICK:
            begin
                if (scale_cnt == '0)
                begin
                    scale_cnt         = scale_rld;
                    res.irq_timer_one = tick_timer(0);
                    res.irq_timer_two = tick_timer(1);
                    if (wd_live)
                    begin
                        // the watchdog fires once, then holds at all ones
                        if (wd_cnt == '0)
                        begin
                            res.irq_watchdog = 1'b1;
                            wd_live          = 1'b0;
                        end
                        wd_cnt = wd_cnt - 1'b1;
                    end
                end
                else
                begin
                    scale_cnt = scale_cnt - 1'b1;
                end
            end
            CMD_WRITE:
            begin
                case (reg_idx_t'(r.reg_index))
                    REG_CNT1:   tmr_cnt[0] = d;
                    REG_RLD1:   tmr_rld[0] = d;
                    REG_CTL1:   set_control(0, d);
                    REG_WDOG:
                    begin
                        wd_cnt  = d;
                        wd_live = 1'b1;
                    end
                    REG_CNT2:   tmr_cnt[1] = d;
                    REG_RLD2:   tmr_rld[1] = d;
                    REG_CTL2:   set_control(1, d);
                    REG_PRECNT: scale_cnt = d;
                    REG_PRERLD: scale_rld = d;
                    default:    ;
                endcase
            end
            CMD_READ:
            begin
                case (reg_idx_t'(r.reg_index))
                    REG_CNT1:   res.read_data = tmr_cnt[0];
                    REG_RLD1:   res.read_data = tmr_rld[0];
                    REG_CTL1:   res.read_data = control_word(0);
                    REG_WDOG:   res.read_data = wd_cnt;
                    REG_CNT2:   res.read_data = tmr_cnt[1];
                    REG_RLD2:   res.read_data = tmr_rld[1];
                    REG_CTL2:   res.read_data = control_word(1);
                    REG_PRECNT: res.read_data = scale_cnt;
                    REG_PRERLD: res.read_data = scale_rld;
                    default:    res.read_data = '0;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] data);
        req_t r;
        r.cmd        = cmd;
        r.reg_index  = idx;
        r.write_data = data;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until accepted. Between bursts,
    // drop valid for a random gap. Predict the response at the accept edge.
    task automatic send_item(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_rsp.push_back(next_response(r));
        burst_left--;
        if (r.cmd != CMD_IDLE_CODE &&
            !(r.cmd == CMD_WRITE && (r.reg_index == REG_HOLE || r.reg_index > REG_PRERLD)))
            useful_items++;
    endtask

    // Pause the request side until every owed response has come back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: stall on a pattern of its own, plus a long hold-off
    // on request, counted here in cycles.
    // ------------------------------------------------------------------
    initial
    begin : response_sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         phase;
        logic       hold_seen;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        hold_seen = 1'b0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:    rsp_if.ready <= 1'b1;
                    SINK_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY:  rsp_if.ready <= (phase % 4 != 3);
                    default:      rsp_if.ready <= (phase % 6 == 0);
                endcase
            end
        end
    end

    task automatic report_mismatch(input string what,
                                   input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        error_count++;
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin : response_check
        rsp_t got;
        rsp_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected response, read_data", '0, got.read_data);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, got.read_data);
                if (got.irq_timer_one !== want.irq_timer_one)
                    report_mismatch("irq_timer_one", want.irq_timer_one, got.irq_timer_one);
                if (got.irq_timer_two !== want.irq_timer_two)
                    report_mismatch("irq_timer_two", want.irq_timer_two, got.irq_timer_two);
                if (got.irq_watchdog !== want.irq_watchdog)
                    report_mismatch("irq_watchdog", want.irq_watchdog, got.irq_watchdog);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // One-shot timer one: underflow from zero raises its interrupt, the
    // counter wraps to all ones and enable clears.
    task automatic test_timer_underflow();
        send_item(make_req(CMD_WRITE, REG_PRERLD, '0));
        send_item(make_req(CMD_WRITE, REG_CNT1, '0));
        send_item(make_req(CMD_WRITE, REG_CTL1, 24'h000001));
        send_item(make_req(CMD_TICK, REG_CNT1, '0));
        send_item(make_req(CMD_READ, REG_CTL1, '0));
        send_item(make_req(CMD_READ, REG_CNT1, '0));
    endtask

    // Timer two: the load bit copies reload into the counter and reads
    // back as zero; auto-reload keeps it running after underflow.
    task automatic test_load_and_reload();
        send_item(make_req(CMD_WRITE, REG_RLD2, 24'hffffff));
        send_item(make_req(CMD_WRITE, REG_CTL2, 24'h000007));
        send_item(make_req(CMD_READ, REG_CNT2, '0));
        send_item(make_req(CMD_TICK, REG_TOP, 24'hffffff));
        send_item(make_req(CMD_READ, REG_CNT2, '0));
        send_item(make_req(CMD_WRITE, REG_CNT2, '0));
        send_item(make_req(CMD_TICK, REG_CNT2, '0));
        send_item(make_req(CMD_READ, REG_CTL2, '0));
    endtask

    // Watchdog arms on write, fires once, then holds without firing again.
    task automatic test_watchdog();
        send_item(make_req(CMD_WRITE, REG_WDOG, '0));
        send_item(make_req(CMD_TICK, REG_WDOG, '0));
        send_item(make_req(CMD_TICK, REG_WDOG, '0));
        send_item(make_req(CMD_READ, REG_WDOG, '0));
    endtask

    // Holes in the register map and the unused command do nothing.
    task automatic test_unused_codes();
        send_item(make_req(CMD_WRITE, REG_HOLE, 24'hffffff));
        send_item(make_req(CMD_READ, REG_HOLE, '0));
        send_item(make_req(CMD_READ, REG_TOP, '0));
        send_item(make_req(CMD_IDLE_CODE, REG_CNT1, 24'hffffff));
        send_item(make_req(CMD_WRITE, REG_TOP, 24'hffffff));
    endtask

    // A non-zero prescaler count just counts down without a timer tick.
    task automatic test_prescaler();
        send_item(make_req(CMD_WRITE, REG_PRECNT, 24'hffffff));
        send_item(make_req(CMD_READ, REG_PRECNT, '0));
        send_item(make_req(CMD_TICK, REG_PRECNT, '0));
        send_item(make_req(CMD_READ, REG_PRECNT, '0));
    endtask

    // Hold the response side off for a long stretch while requests keep
    // coming back to back, so the output register fills and ready drops.
    task automatic test_backpressure();
        gaps_on    = 1'b0;
        hold_token <= ~hold_token;
        repeat (24)
        begin
            if ($urandom_range(0, 2) == 0)
                send_item(make_req(CMD_READ, 4'($urandom_range(0, 15)), '0));
            else
                send_item(make_req(CMD_TICK, 4'($urandom), 24'($urandom)));
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // Counter values: mostly small so timers and the watchdog actually
    // underflow, sometimes all ones or fully random.
    function automatic logic [DATA_W-1:0] count_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return DATA_W'($urandom_range(0, 6));
        else if (pick < 88)
            return '1;
        else
            return DATA_W'($urandom);
    endfunction

    // Control words: random low bits, junk in the upper bits now and then.
    function automatic logic [DATA_W-1:0] ctl_value();
        logic [DATA_W-1:0] w;
        w = DATA_W'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0)
            w = w | (DATA_W'($urandom) & 24'hfffff8);
        return w;
    endfunction

    // Anything the fields allow.
    function automatic req_t noise_req();
        return make_req(CMD_W'($urandom), IDX_W'($urandom), DATA_W'($urandom));
    endfunction

    // Well-formed run: set up the prescaler and timers, maybe arm the
    // watchdog, then tick with reads mixed in.
    task automatic run_scenario();
        int t;
        gaps_on = ($urandom_range(0, 3) != 0);
        send_item(make_req(CMD_WRITE, REG_PRERLD, DATA_W'($urandom_range(0, 3))));
        send_item(make_req(CMD_WRITE, REG_PRECNT, DATA_W'($urandom_range(0, 3))));
        repeat ($urandom_range(1, 3))
        begin
            t = $urandom_range(0, 1);
            send_item(make_req(CMD_WRITE, t ? REG_RLD2 : REG_RLD1, count_value()));
            if ($urandom_range(0, 1))
                send_item(make_req(CMD_WRITE, t ? REG_CNT2 : REG_CNT1, count_value()));
            send_item(make_req(CMD_WRITE, t ? REG_CTL2 : REG_CTL1, ctl_value()));
        end
        if ($urandom_range(0, 2) == 0)
            send_item(make_req(CMD_WRITE, REG_WDOG, count_value()));
        repeat ($urandom_range(8, 30))
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(make_req(CMD_READ, IDX_W'($urandom_range(0, 15)), 24'($urandom)));
            else
                send_item(make_req(CMD_TICK, IDX_W'($urandom), DATA_W'($urandom)));
        end
    endtask

    task automatic test_random_traffic();
        int runs;
        runs = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                run_scenario();
            end
            else
            begin
                gaps_on = 1'b1;
                repeat ($urandom_range(4, 12))
                    send_item(noise_req());
            end
            runs++;
            // now and then let everything come back before going on
            if (runs % 9 == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        scale_cnt  = '0;
        scale_rld  = '0;
        tmr_cnt    = '{default: '0};
        tmr_rld    = '{default: '0};
        tmr_on     = '{default: 1'b0};
        tmr_repeat = '{default: 1'b0};
        wd_cnt     = '0;
        wd_live    = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_timer_underflow();
        test_load_and_reload();
        test_watchdog();
        test_unused_codes();
        test_prescaler();
        // pause here until the directed responses are all back
        wait_drained();
        test_backpressure();
        useful_items = 0;
        test_random_traffic();

        // drain, then keep watching the response side for stray responses
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run.
    initial
    begin : run_limit
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hdl/pdtw_pkg.sv
hdl/pdtw_stream_if.sv
hdl/prescaled_dual_timer_watchdog.sv
hdl/pdtw_checker.sv
tb/sv/prescaled_dual_timer_watchdog_tb.sv
